@@ sv/bbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and arithmetic helpers for the BC1/BC3 block decoder.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic FmtBc1 = 1'b0;
    localparam logic FmtBc3 = 1'b1;

    localparam logic [1:0] LastRow = 2'd3;

    // Classified block: widened endpoints and the weighted sums
    typedef struct packed {
        logic              bc3;
        logic              four_color;
        logic [2:0][7:0]   e0;
        logic [2:0][7:0]   e1;
        logic [2:0][9:0]   s_a;
        logic [2:0][9:0]   s_b;
        logic [2:0][8:0]   s_mid;
        logic [7:0]        a0;
        logic [7:0]        a1;
        logic              a_eight;
        logic [5:0][10:0]  a7;
        logic [3:0][10:0]  a5;
        logic [31:0]       cidx;
        logic [47:0]       aidx;
    } t_front;

    // Decoded block: palettes plus the index words
    typedef struct packed {
        logic              bc3;
        logic              three;
        logic [3:0][23:0]  pal;
        logic [7:0][7:0]   apal;
        logic [31:0]       cidx;
        logic [47:0]       aidx;
    } t_block;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [2:0] f;
        f = 3'd0;
        f = f + {2'b0, (v >= 5'd5)};
        f = f + {2'b0, (v >= 5'd9)};
        f = f + {2'b0, (v >= 5'd14)};
        f = f + {2'b0, (v >= 5'd18)};
        f = f + {2'b0, (v >= 5'd23)};
        f = f + {2'b0, (v >= 5'd27)};
        f = f + {2'b0, (v == 5'd31)};
        return {v, 3'b000} + {5'b0, f};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] f;
        f = 2'd0;
        f = f + {1'b0, (v >= 6'd21)};
        f = f + {1'b0, (v >= 6'd42)};
        f = f + {1'b0, (v == 6'd63)};
        return {v, 2'b00} + {6'b0, f};
    endfunction

    // x / 3 for x <= 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    // x / 7 for x <= 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return p[21:14];
    endfunction

    // x / 5 for x <= 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd3277;
        return p[21:14];
    endfunction

endpackage

@@ sv/bbd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_front
// Accepts compressed blocks, classifies the color and alpha modes and
// builds both palettes for the block queue.
// ----------------------------------------------------------------------------
module bbd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic            i_bc3,
    input  logic [15:0]     i_color_end0,
    input  logic [15:0]     i_color_end1,
    input  logic [31:0]     i_color_index_word,
    input  logic [7:0]      i_alpha_end0,
    input  logic [7:0]      i_alpha_end1,
    input  logic [47:0]     i_alpha_index_word,
    input  logic            i_q_full,
    output logic            o_q_push,
    output bbd_pkg::t_block o_q_data
);
    import bbd_pkg::*;

    logic   r_s1_v;
    t_front r_s1;
    t_front n_s1;
    logic   accept;

    assign full     = r_s1_v && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_s1_v && !i_q_full;

    always_comb begin
        n_s1            = '0;
        n_s1.bc3        = i_bc3;
        n_s1.four_color = i_bc3 || (i_color_end0 > i_color_end1);
        n_s1.e0[0]      = expand5(i_color_end0[15:11]);
        n_s1.e0[1]      = expand6(i_color_end0[10:5]);
        n_s1.e0[2]      = expand5(i_color_end0[4:0]);
        n_s1.e1[0]      = expand5(i_color_end1[15:11]);
        n_s1.e1[1]      = expand6(i_color_end1[10:5]);
        n_s1.e1[2]      = expand5(i_color_end1[4:0]);
        for (int ch = 0; ch < 3; ch++) begin
            n_s1.s_a[ch]   = {1'b0, n_s1.e0[ch], 1'b0} + {2'b0, n_s1.e1[ch]};
            n_s1.s_b[ch]   = {2'b0, n_s1.e0[ch]} + {1'b0, n_s1.e1[ch], 1'b0};
            n_s1.s_mid[ch] = {1'b0, n_s1.e0[ch]} + {1'b0, n_s1.e1[ch]};
        end
        n_s1.a0      = i_alpha_end0;
        n_s1.a1      = i_alpha_end1;
        n_s1.a_eight = i_alpha_end0 > i_alpha_end1;
        for (int k = 1; k <= 6; k++) begin
            n_s1.a7[k-1] = 11'(i_alpha_end0) * 11'(7 - k) + 11'(i_alpha_end1) * 11'(k);
        end
        for (int k = 1; k <= 4; k++) begin
            n_s1.a5[k-1] = 11'(i_alpha_end0) * 11'(5 - k) + 11'(i_alpha_end1) * 11'(k);
        end
        n_s1.cidx = i_color_index_word;
        n_s1.aidx = i_alpha_index_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (o_q_push) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // Build palettes from the stored sums
    always_comb begin
        logic [2:0][7:0] p2;
        logic [2:0][7:0] p3;
        o_q_data       = '0;
        o_q_data.bc3   = r_s1.bc3;
        o_q_data.three = !r_s1.four_color;
        for (int ch = 0; ch < 3; ch++) begin
            if (r_s1.four_color) begin
                p2[ch] = div3(r_s1.s_a[ch]);
                p3[ch] = div3(r_s1.s_b[ch]);
            end else begin
                p2[ch] = r_s1.s_mid[ch][8:1];
                p3[ch] = 8'd0;
            end
        end
        o_q_data.pal[0] = {r_s1.e0[2], r_s1.e0[1], r_s1.e0[0]};
        o_q_data.pal[1] = {r_s1.e1[2], r_s1.e1[1], r_s1.e1[0]};
        o_q_data.pal[2] = {p2[2], p2[1], p2[0]};
        o_q_data.pal[3] = {p3[2], p3[1], p3[0]};
        o_q_data.apal[0] = r_s1.a0;
        o_q_data.apal[1] = r_s1.a1;
        if (r_s1.a_eight) begin
            for (int k = 0; k < 6; k++) begin
                o_q_data.apal[k+2] = div7(r_s1.a7[k]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                o_q_data.apal[k+2] = div5(r_s1.a5[k]);
            end
            o_q_data.apal[6] = 8'd0;
            o_q_data.apal[7] = 8'd255;
        end
        o_q_data.cidx = r_s1.cidx;
        o_q_data.aidx = r_s1.aidx;
    end

endmodule

@@ sv/bbd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_queue
// Short queue of decoded blocks between the front and back halves.
// ----------------------------------------------------------------------------
module bbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bbd_pkg::t_block i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bbd_pkg::t_block o_data
);
    import bbd_pkg::*;

    t_block             r_mem [QDepth];
    logic [QPtrW-1:0]   r_wptr;
    logic [QPtrW-1:0]   r_rptr;
    logic [QCntW-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = r_count == QCntW'(QDepth);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPtrW'(QDepth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPtrW'(QDepth - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ sv/bbd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_back
// Walks the four rows of a decoded block and looks up each texel in the
// palettes, one row per beat into the output register.
// ----------------------------------------------------------------------------
module bbd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  bbd_pkg::t_block i_q_data,
    output logic            o_q_pop,
    output logic            empty,
    input  logic            pop,
    output logic [1:0]      o_row_number,
    output logic [31:0]     o_texel_a,
    output logic [31:0]     o_texel_b,
    output logic [31:0]     o_texel_c,
    output logic [31:0]     o_texel_d,
    output logic            o_last_row
);
    import bbd_pkg::*;

    logic             r_v;
    logic [1:0]       r_row;
    logic [1:0]       r_row_out;
    logic             r_last;
    logic [3:0][31:0] r_tex;
    logic [3:0][31:0] n_tex;
    logic [7:0]       row_c;
    logic [11:0]      row_a;
    logic             load;

    assign load    = !i_q_empty && (!r_v || pop);
    assign o_q_pop = load && (r_row == LastRow);
    assign empty   = !r_v;

    always_comb begin
        unique case (r_row)
            2'd0: begin
                row_c = i_q_data.cidx[7:0];
                row_a = i_q_data.aidx[11:0];
            end
            2'd1: begin
                row_c = i_q_data.cidx[15:8];
                row_a = i_q_data.aidx[23:12];
            end
            2'd2: begin
                row_c = i_q_data.cidx[23:16];
                row_a = i_q_data.aidx[35:24];
            end
            default: begin
                row_c = i_q_data.cidx[31:24];
                row_a = i_q_data.aidx[47:36];
            end
        endcase
    end

    always_comb begin
        logic [1:0] ci;
        logic [2:0] ai;
        logic [7:0] a;
        for (int c = 0; c < 4; c++) begin
            ci = row_c[2*c +: 2];
            ai = row_a[3*c +: 3];
            if (i_q_data.bc3) begin
                a = i_q_data.apal[ai];
            end else if (i_q_data.three && ci == 2'd3) begin
                a = 8'd0;
            end else begin
                a = 8'd255;
            end
            n_tex[c] = {a, i_q_data.pal[ci]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_row <= 2'd0;
        end else begin
            if (load) begin
                r_v   <= 1'b1;
                r_row <= r_row + 1'b1;
            end else if (pop) begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_row_out <= r_row;
            r_last    <= r_row == LastRow;
            r_tex     <= n_tex;
        end
    end

    assign o_row_number = r_row_out;
    assign o_texel_a    = r_tex[0];
    assign o_texel_b    = r_tex[1];
    assign o_texel_c    = r_tex[2];
    assign o_texel_d    = r_tex[3];
    assign o_last_row   = r_last;

endmodule

@@ sv/bc1_bc3_block_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_bc3_block_decoder_core
// BC1/BC3 4x4 texel block decoder with queue-style ports.
//
// Input side: drive one compressed block on the i_* fields with push; it is
// taken on an edge where push is high and full is low. Output side: while
// empty is low, one row of four RGBA8 texels sits on the o_* ports; pop
// takes it. Each block gives four rows, top first, o_last_row on row 3.
// Configuration: i_cfg_data selects BC1 (0) or BC3 (1); it is written when
// i_cfg_valid is high (o_cfg_ready is always high) and applies to blocks
// taken after the write.
// A block taken is held in the front register, then enters the queue, then
// its first row is loaded into the output register; a full queue or a held
// row can stall it. Throughput: one row per cycle from the output register
// while pop keeps up and the queue is not empty.
// The front keeps accepting blocks into a two-entry queue while rows wait.
// Reset clears the format to BC1 and empties all stages. When pop is held
// low, the row holds and the queue fills, then full rises.
// ----------------------------------------------------------------------------
module bc1_bc3_block_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_color_end0,
    input  logic [15:0] i_color_end1,
    input  logic [31:0] i_color_index_word,
    input  logic [7:0]  i_alpha_end0,
    input  logic [7:0]  i_alpha_end1,
    input  logic [47:0] i_alpha_index_word,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_row_number,
    output logic [31:0] o_texel_a,
    output logic [31:0] o_texel_b,
    output logic [31:0] o_texel_c,
    output logic [31:0] o_texel_d,
    output logic        o_last_row
);
    import bbd_pkg::*;

    logic   r_block_format;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    t_block q_wdata;
    t_block q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_format <= FmtBc1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_block_format <= i_cfg_data;
        end
    end

    bbd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_bc3              (r_block_format == FmtBc3),
        .i_color_end0       (i_color_end0),
        .i_color_end1       (i_color_end1),
        .i_color_index_word (i_color_index_word),
        .i_alpha_end0       (i_alpha_end0),
        .i_alpha_end1       (i_alpha_end1),
        .i_alpha_index_word (i_alpha_index_word),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_data           (q_wdata)
    );

    bbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    bbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_rdata),
        .o_q_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .o_row_number (o_row_number),
        .o_texel_a    (o_texel_a),
        .o_texel_b    (o_texel_b),
        .o_texel_c    (o_texel_c),
        .o_texel_d    (o_texel_d),
        .o_last_row   (o_last_row)
    );

endmodule
